// File: rtl/sratd_pkg.sv
// shared types, constants and helper functions for the radix-to-ascii converter
package sratd_pkg;

  localparam int VALUE_W          = 32;
  localparam int RADIX_W          = 5;
  localparam int DIGIT_W          = 4;
  localparam int CHAR_W           = 7;
  localparam int OUT_DATA_W       = 8;
  localparam int MAX_DIGITS_DEF   = 32;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_STEPS        = 8;
  localparam int DIV_CYCLES       = VALUE_W / DIV_STEPS;
  localparam int DIV_STEP_W       = $clog2(DIV_CYCLES);

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < 4'd10) begin
      res = CH_ZERO + {3'b000, d};
    end else begin
      res = CH_UPPER_A + {3'b000, d - 4'd10};
    end
    return res;
  endfunction

endpackage

// File: rtl/sratd_front.sv
// input side: accepts values, splits sign and magnitude, holds them in a small queue
module sratd_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sratd_pkg::VALUE_W-1:0]   in_tdata,   // value
  output logic                            q_valid,
  input  logic                            q_ready,
  output sratd_pkg::item_t                q_item
);
  import sratd_pkg::*;

  item_t                  entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   push, pop;
  item_t                  new_item;

  assign in_tready = (count_r < QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_valid   = (count_r != '0);
  assign q_item    = entry_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    new_item.neg = in_tdata[VALUE_W-1];
    new_item.mag = in_tdata[VALUE_W-1] ? (VALUE_W'(0) - in_tdata) : in_tdata;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// File: rtl/sratd_back.sv
// output side: digit-by-digit long division into the digit store, then character emission
module sratd_back #(
  parameter int MAX_DIGITS = sratd_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [sratd_pkg::RADIX_W-1:0]   radix,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  sratd_pkg::item_t                q_item,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sratd_pkg::CHAR_W-1:0]    out_char,
  output logic                            out_last
);
  import sratd_pkg::*;

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_READ = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [VALUE_W-1:0]  work_r, work_nxt;
  logic [DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [DIV_STEP_W-1:0] step_r, step_nxt;
  logic                neg_r, neg_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;
  logic [DIGIT_W-1:0]  digit_mem [MAX_DIGITS];
  logic [DIGIT_W-1:0]  rd_data_r;

  logic [RADIX_W-1:0]  rem_v;
  logic [VALUE_W-1:0]  work_v;
  logic                mem_we;
  logic                slot_free;
  logic                store_room;
  logic [CW-1:0]       cnt_done;

  assign q_ready    = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;
  assign slot_free  = !out_valid_r || out_tready;
  assign store_room = (cnt_r < CW'(MAX_DIGITS));

  // eight restoring-division steps per cycle, remainder stays below twice the radix
  always_comb begin
    rem_v  = {1'b0, rem_r};
    work_v = work_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_v  = {rem_v[DIGIT_W-1:0], work_v[VALUE_W-1]};
      work_v = {work_v[VALUE_W-2:0], 1'b0};
      if (rem_v >= radix) begin
        rem_v     = rem_v - radix;
        work_v[0] = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    cnt_done      = store_room ? cnt_r + 1'b1 : cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          work_nxt  = q_item.mag;
          neg_nxt   = q_item.neg;
          rem_nxt   = '0;
          step_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        work_nxt = work_v;
        if (step_r == DIV_STEP_W'(DIV_CYCLES - 1)) begin
          mem_we   = store_room;
          cnt_nxt  = cnt_done;
          rem_nxt  = '0;
          step_nxt = '0;
          if (work_v == '0) begin
            idx_nxt   = AW'(cnt_done - 1'b1);
            state_nxt = neg_r ? ST_SIGN : ST_READ;
          end
        end else begin
          rem_nxt  = rem_v[DIGIT_W-1:0];
          step_nxt = step_r + 1'b1;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(rd_data_r);
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // digit store, least significant digit at entry zero
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[cnt_r[AW-1:0]] <= rem_v[DIGIT_W-1:0];
    end
    rd_data_r <= digit_mem[idx_r];
  end

endmodule

// File: rtl/signed_radix_to_ascii_digits.sv
// top level: signed integer to ascii digit string in a configurable radix
// digits come one per long division of the 32-bit magnitude, 8 quotient bits per cycle,
//   and go out most significant first, after a minus sign for a negative value;
//   output stalls hold the emitter, and a two-entry input queue takes new values while
//   the divider and emitter are busy
// reset (rst_n low, synchronous): queue and control cleared, radix back to 10,
//   digit store contents left as they are
module signed_radix_to_ascii_digits #(
  parameter int MAX_DIGITS = sratd_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sratd_pkg::VALUE_W-1:0]     in_tdata,   // value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sratd_pkg::OUT_DATA_W-1:0]  out_tdata,  // character, zero pad bit
  output logic                              out_tlast,  // final_char
  input  logic                              cfg_we,
  input  logic [sratd_pkg::RADIX_W-1:0]     cfg_wdata   // radix
);
  import sratd_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  logic               q_valid;
  logic               q_ready;
  item_t              q_item;
  logic [CHAR_W-1:0]  out_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  sratd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  sratd_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .radix      (eff_radix(radix_r)),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_char),
    .out_last   (out_tlast)
  );

  assign out_tdata = {{(OUT_DATA_W - CHAR_W){1'b0}}, out_char};

endmodule

// File: rtl/sratd_checker.sv
// port-level checks on the converter, bound to the top level
module sratd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [sratd_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                              out_tlast
);
  import sratd_pkg::*;

  // stalled beat stays up
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out beat dropped while stalled");

  // stalled beat keeps its payload
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("out payload changed while stalled");

  // minus sign always has digits after it
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[CHAR_W-1:0] == CH_MINUS) |-> !out_tlast)
    else $error("minus sign marked as last character");

  // reset empties output and opens the input queue
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear output or open input");

endmodule

bind signed_radix_to_ascii_digits sratd_checker u_sratd_checker (.*);
